>>> hw/rtl/gn2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared constants for the 2D gradient noise pixel unit: field widths,
// register indexes and reset values, and the fixed permutation table.
// ----------------------------------------------------------------------------
package gn2d_pkg;

  localparam int COORD_W       = 17;
  localparam int RES_W         = 16;
  localparam int BAND_W        = 8;
  localparam int NOISE_W       = 16;
  localparam int PIX_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int TABLE_SIZE    = 256;
  localparam int CELL_W        = 8;
  localparam int FRAC_BITS_DEF = 16;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH  = 2'd2;

  localparam logic [RES_W-1:0]  RESOLUTION_RST = 16'd200;
  localparam logic [BAND_W-1:0] BAND_LOW_RST   = 8'd150;
  localparam logic [BAND_W-1:0] BAND_HIGH_RST  = 8'd156;

  // 1/sqrt(2) in Q1.15
  localparam logic [15:0] GRAD_DIAG = 16'd23170;

  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  localparam logic [7:0] PERM [TABLE_SIZE] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

endpackage

>>> hw/rtl/gradient_noise_2d_pixel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_pixel_unit
// 2D gradient (Perlin) noise for one pixel coord pair per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, coord_x, coord_y) takes one coordinate
//   pair per transaction. Output channel (out_valid/out_ready, noise_value,
//   intensity, pixel) returns exactly one result per input, in order.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   resolution (0), band_low (1), band_high (2); cfg_ready is always high.
//   Write config only while the pipeline is empty.
// Pipeline: the divider resolves one quotient bit per stage, followed by
//   seven stages for hashing, fade, dot products, two blend levels, scaling
//   and output.
// Throughput: one transaction per cycle in and out when not stalled.
// Stall: when out_valid is high and out_ready low, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated. Bubbles travel as
//   invalid stages.
// Reset: clears all valid bits and loads resolution 200, band 150..156.
// ----------------------------------------------------------------------------
module gradient_noise_2d_pixel_unit #(
  parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [gn2d_pkg::COORD_W-1:0]          coord_x,
  input  logic [gn2d_pkg::COORD_W-1:0]          coord_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gn2d_pkg::NOISE_W-1:0]   noise_value,
  output logic [gn2d_pkg::PIX_W-1:0]            intensity,
  output logic [gn2d_pkg::PIX_W-1:0]            pixel,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gn2d_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gn2d_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int F   = FRAC_BITS;
  localparam int DW  = gn2d_pkg::COORD_W + F;
  localparam int CW  = gn2d_pkg::CELL_W;
  localparam int VW  = F + 6;
  localparam int EW  = VW + 16;
  localparam int SR  = (F >= 15) ? F - 15 : 0;
  localparam int SL  = (F < 15) ? 15 - F : 0;
  localparam logic signed [VW-1:0] ONE = VW'(1) <<< F;

  // ---------------- config registers ----------------
  logic [gn2d_pkg::RES_W-1:0]  resolution;
  logic [gn2d_pkg::BAND_W-1:0] band_low;
  logic [gn2d_pkg::BAND_W-1:0] band_high;
  logic [gn2d_pkg::RES_W-1:0]  divisor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= gn2d_pkg::RESOLUTION_RST;
      band_low   <= gn2d_pkg::BAND_LOW_RST;
      band_high  <= gn2d_pkg::BAND_HIGH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        gn2d_pkg::REG_RESOLUTION: resolution <= cfg_data;
        gn2d_pkg::REG_BAND_LOW:   band_low   <= cfg_data[gn2d_pkg::BAND_W-1:0];
        gn2d_pkg::REG_BAND_HIGH:  band_high  <= cfg_data[gn2d_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // zero resolution acts as one
  assign divisor = (resolution == '0) ? gn2d_pkg::RES_W'(1) : resolution;

  // ---------------- pipeline control ----------------
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic          dv;
  logic [DW-1:0] qx, qy;

  gn2d_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .coord_x (coord_x),
    .coord_y (coord_y),
    .divisor (divisor),
    .out_vld (dv),
    .quot_x  (qx),
    .quot_y  (qy)
  );

  // ---------------- helpers ----------------
  function automatic logic signed [VW-1:0] dot_corner(
    input logic [2:0] g, input logic signed [VW-1:0] dx, input logic signed [VW-1:0] dy
  );
    logic signed [VW:0]   sel;
    logic signed [EW-1:0] raw;
    begin
      case (g)
        3'd0:    sel = dx + dy;
        3'd1:    sel = dy - dx;
        3'd2:    sel = dx - dy;
        3'd3:    sel = -(dx + dy);
        3'd4:    sel = dx;
        3'd5:    sel = -dx;
        3'd6:    sel = dy;
        default: sel = -dy;
      endcase
      if (g[2]) begin
        raw = EW'(sel) <<< 15;
      end else begin
        raw = EW'(sel) * $signed({1'b0, gn2d_pkg::GRAD_DIAG});
      end
      dot_corner = VW'(raw >>> 15);
    end
  endfunction

  function automatic logic signed [VW-1:0] blend(
    input logic signed [VW-1:0] a, input logic signed [VW-1:0] b, input logic signed [VW-1:0] c
  );
    logic signed [VW:0]     d;
    logic signed [2*VW:0]   p;
    begin
      d = (VW+1)'(b) - (VW+1)'(a);
      p = (2*VW+1)'(c) * (2*VW+1)'(d);
      blend = a + VW'(p >>> F);
    end
  endfunction

  // ---------------- stage 1: cell hash, t^2 ----------------
  logic          s1_vld;
  logic [CW-1:0] s1_ix, s1_h0, s1_h1;
  logic [F-1:0]  s1_fx, s1_fy, s1_t2x, s1_t2y;
  logic [CW-1:0] iy_c;
  logic [2*F-1:0] sqx, sqy;

  assign iy_c = qy[F+CW-1:F];
  assign sqx  = qx[F-1:0] * qx[F-1:0];
  assign sqy  = qy[F-1:0] * qy[F-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ix  <= qx[F+CW-1:F];
      s1_h0  <= gn2d_pkg::PERM[iy_c];
      s1_h1  <= gn2d_pkg::PERM[CW'(iy_c + CW'(1))];
      s1_fx  <= qx[F-1:0];
      s1_fy  <= qy[F-1:0];
      s1_t2x <= sqx[2*F-1:F];
      s1_t2y <= sqy[2*F-1:F];
    end
  end

  // ---------------- stage 2: corner gradients, t^3 ----------------
  logic          s2_vld;
  logic [2:0]    s2_g00, s2_g10, s2_g01, s2_g11;
  logic [F-1:0]  s2_fx, s2_fy, s2_t2x, s2_t2y, s2_t3x, s2_t3y;
  logic [CW-1:0] ix1;
  logic [2*F-1:0] cbx, cby;
  logic [7:0]    e00, e10, e01, e11;

  assign ix1 = CW'(s1_ix + CW'(1));
  assign cbx = s1_t2x * s1_fx;
  assign cby = s1_t2y * s1_fy;
  assign e00 = gn2d_pkg::PERM[CW'(s1_ix + s1_h0)];
  assign e10 = gn2d_pkg::PERM[CW'(ix1 + s1_h0)];
  assign e01 = gn2d_pkg::PERM[CW'(s1_ix + s1_h1)];
  assign e11 = gn2d_pkg::PERM[CW'(ix1 + s1_h1)];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_g00 <= e00[2:0];
      s2_g10 <= e10[2:0];
      s2_g01 <= e01[2:0];
      s2_g11 <= e11[2:0];
      s2_fx  <= s1_fx;
      s2_fy  <= s1_fy;
      s2_t2x <= s1_t2x;
      s2_t2y <= s1_t2y;
      s2_t3x <= cbx[2*F-1:F];
      s2_t3y <= cby[2*F-1:F];
    end
  end

  // ---------------- stage 3: dot products, fade ----------------
  logic                 s3_vld;
  logic signed [VW-1:0] s3_s, s3_t, s3_u, s3_v, s3_wx, s3_wy;
  logic signed [VW-1:0] dx0, dy0, dx1, dy1;

  assign dx0 = VW'({1'b0, s2_fx});
  assign dy0 = VW'({1'b0, s2_fy});
  assign dx1 = dx0 - ONE;
  assign dy1 = dy0 - ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_s  <= dot_corner(s2_g00, dx0, dy0);
      s3_t  <= dot_corner(s2_g10, dx1, dy0);
      s3_u  <= dot_corner(s2_g01, dx0, dy1);
      s3_v  <= dot_corner(s2_g11, dx1, dy1);
      s3_wx <= VW'({1'b0, s2_t2x}) * VW'(3) - VW'({1'b0, s2_t3x}) * VW'(2);
      s3_wy <= VW'({1'b0, s2_t2y}) * VW'(3) - VW'({1'b0, s2_t3y}) * VW'(2);
    end
  end

  // ---------------- stage 4: blend along x ----------------
  logic                 s4_vld;
  logic signed [VW-1:0] s4_r0, s4_r1, s4_wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r0 <= blend(s3_s, s3_t, s3_wx);
      s4_r1 <= blend(s3_u, s3_v, s3_wx);
      s4_wy <= s3_wy;
    end
  end

  // ---------------- stage 5: blend along y ----------------
  logic                 s5_vld;
  logic signed [VW-1:0] s5_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_val <= blend(s4_r0, s4_r1, s4_wy);
    end
  end

  // ---------------- stage 6: Q1.15 scaling and saturation ----------------
  logic                                s6_vld;
  logic signed [gn2d_pkg::NOISE_W-1:0] s6_q;
  logic signed [EW-1:0]                scl;
  logic signed [gn2d_pkg::NOISE_W-1:0] sat;

  assign scl = (EW'(s5_val) <<< SL) >>> SR;

  always_comb begin
    if (scl > EW'(32767)) begin
      sat = 16'sh7FFF;
    end else if (scl < -EW'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = scl[gn2d_pkg::NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (en) begin
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_q <= sat;
    end
  end

  // ---------------- stage 7: intensity, contour pixel, output ----------------
  logic [gn2d_pkg::NOISE_W-1:0] ofs;
  logic [23:0]                  iprod;
  logic [7:0]                   inten;

  assign ofs   = {~s6_q[15], s6_q[14:0]};
  assign iprod = {ofs, 8'd0} - {8'd0, ofs};
  assign inten = iprod[23:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      noise_value <= s6_q;
      intensity   <= inten;
      pixel       <= (inten >= band_low && inten <= band_high) ?
                     gn2d_pkg::PIX_BLACK : gn2d_pkg::PIX_WHITE;
    end
  end

endmodule

>>> hw/rtl/gn2d_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_div
// Pipelined restoring divider, two lanes. Divides {coord, FRAC_BITS zeros}
// by the resolution, one quotient bit per stage; the quotient holds the grid
// cell in its upper bits and the Q0.FRAC_BITS fraction in its lower bits.
// ----------------------------------------------------------------------------
module gn2d_div #(
  parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_vld,
  input  logic [gn2d_pkg::COORD_W-1:0]           coord_x,
  input  logic [gn2d_pkg::COORD_W-1:0]           coord_y,
  input  logic [gn2d_pkg::RES_W-1:0]             divisor,
  output logic                                   out_vld,
  output logic [gn2d_pkg::COORD_W+FRAC_BITS-1:0] quot_x,
  output logic [gn2d_pkg::COORD_W+FRAC_BITS-1:0] quot_y
);

  localparam int DW = gn2d_pkg::COORD_W + FRAC_BITS;
  localparam int RW = gn2d_pkg::RES_W;

  logic          vld [DW];
  logic [DW-1:0] nx  [DW];
  logic [DW-1:0] ny  [DW];
  logic [RW-1:0] rx  [DW];
  logic [RW-1:0] ry  [DW];

  genvar k;
  generate
    for (k = 0; k < DW; k++) begin : g_stage
      logic          pv;
      logic [DW-1:0] px, py;
      logic [RW-1:0] prx, pry;
      logic [RW:0]   tx, ty;
      logic          gex, gey;

      if (k == 0) begin : g_first
        assign pv  = in_vld;
        assign px  = {coord_x, {FRAC_BITS{1'b0}}};
        assign py  = {coord_y, {FRAC_BITS{1'b0}}};
        assign prx = '0;
        assign pry = '0;
      end else begin : g_next
        assign pv  = vld[k-1];
        assign px  = nx[k-1];
        assign py  = ny[k-1];
        assign prx = rx[k-1];
        assign pry = ry[k-1];
      end

      // shift in the next dividend bit, subtract when it fits
      assign tx  = {prx, px[DW-1]};
      assign ty  = {pry, py[DW-1]};
      assign gex = tx >= {1'b0, divisor};
      assign gey = ty >= {1'b0, divisor};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          nx[k] <= {px[DW-2:0], gex};
          ny[k] <= {py[DW-2:0], gey};
          rx[k] <= gex ? RW'(tx - {1'b0, divisor}) : tx[RW-1:0];
          ry[k] <= gey ? RW'(ty - {1'b0, divisor}) : ty[RW-1:0];
        end
      end
    end
  endgenerate

  assign out_vld = vld[DW-1];
  assign quot_x  = nx[DW-1];
  assign quot_y  = ny[DW-1];

endmodule

>>> hw/rtl/gn2d_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_chk
// Port-level checks for the gradient noise pixel unit, bound to the top.
// ----------------------------------------------------------------------------
module gn2d_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] noise_value,
  input logic [7:0]         intensity,
  input logic [7:0]         pixel
);

  logic [23:0] exp_prod;
  assign exp_prod = {~noise_value[15], noise_value[14:0], 8'd0}
                  - {8'd0, ~noise_value[15], noise_value[14:0]};

  // a stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(noise_value) && $stable(pixel))
    else $error("output transaction changed while stalled");

  // no new input while a result is stalled
  a_in_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

  // intensity follows from the noise value
  a_inten: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> intensity == exp_prod[23:16])
    else $error("intensity does not match noise value");

  a_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel == 8'd0 || pixel == 8'd255)
    else $error("pixel is neither black nor white");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind gradient_noise_2d_pixel_unit gn2d_chk u_gn2d_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .noise_value (noise_value),
  .intensity   (intensity),
  .pixel       (pixel)
);
